/* design/sha256_hash_engine_defines.svh */
// Assertion macros for the SHA-256 hash engine.
`ifndef SHA256_HASH_ENGINE_DEFINES_SVH
`define SHA256_HASH_ENGINE_DEFINES_SVH
`ifndef SYNTH
`define SHA_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SHA_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SHA_ASSERT(label, clk, rst, prop, msg)
`define SHA_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

/* design/sha256_pkg.sv */
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared types, constants and round functions of the SHA-256 hash engine.
// ----------------------------------------------------------------------------
`default_nettype none
package sha256_pkg;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned CmdDepth = 4;

  typedef enum logic [1:0] {
    CMD_WORD  = 2'd0,
    CMD_FINAL = 2'd1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [31:0] word;
    logic [2:0]  count;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_PAD_WORD,
    ST_PAD_FILL,
    ST_DBL_LOAD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic busy;
    logic emitting;
  } status_t;

  localparam logic [255:0] IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] PAD_WORD = 32'h80000000;
  localparam logic [3:0] LEN_SLOT = 4'd14;

  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

/* design/sha256_hash_engine.sv */
// SHA-256 engine: each block runs 64 rounds, one round per cycle, followed by a fold.
// Full words are taken while idle; a 16th word starts the block, and none is taken until it ends.
// A final word adds padding writes, one or two blocks, and one more block in double mode.
// The four digest parts follow as four transfers through the queue-style result port.
// Reset (rst, synchronous, active high) loads the initial hash values and clears counts.
// ----------------------------------------------------------------------------
// SHA-256 hash engine top level
// Queue-style input and output around a command queue and a round core.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sha256_hash_engine_defines.svh"
module sha256_hash_engine #(
  parameter int unsigned CMD_DEPTH = sha256_pkg::CmdDepth
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_data,
  input  wire logic        push,
  output logic             full,
  input  wire logic [31:0] data_word,
  input  wire logic [2:0]  byte_count,
  input  wire logic        last_word,
  output logic             empty,
  input  wire logic        pop,
  output logic [63:0]      digest_part,
  output logic [1:0]       part_index,
  output logic             last_part
);
  logic double_mode;
  logic cmd_valid;
  logic cmd_take;
  sha256_pkg::cmd_t cmd;
  logic res_valid;
  logic [63:0] res_digest;
  logic [1:0] res_index;
  sha256_pkg::status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      double_mode <= 1'b0;
    end else if (cfg_we) begin
      double_mode <= cfg_data;
    end
  end

  sha256_front #(.DEPTH(CMD_DEPTH)) u_front (
    .clk, .rst, .push, .full, .data_word, .byte_count, .last_word,
    .cmd_valid, .cmd_take, .cmd
  );

  sha256_core u_core (
    .clk, .rst, .double_mode, .cmd_valid, .cmd_take, .cmd,
    .res_valid, .res_take(pop), .res_digest, .res_index, .status
  );

  assign empty = !res_valid;
  assign digest_part = res_digest;
  assign part_index = res_index;
  assign last_part = (res_index == 2'd3);

  `SHA_ASSERT(a_emit_busy, clk, rst, status.emitting |-> status.busy, "emit while idle")
  `SHA_ASSERT(a_last_idx, clk, rst, (!empty && last_part) |-> part_index == 2'd3,
    "last flag on wrong part")
  `SHA_ASSERT(a_pop_valid, clk, rst, (pop && !empty && part_index == 2'd3) |=> empty,
    "results continue after last part")
endmodule
`default_nettype wire

/* design/sha256_front.sv */
// ----------------------------------------------------------------------------
// SHA-256 front end
// Accepts message words, classifies them and queues commands for the core.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sha256_hash_engine_defines.svh"
module sha256_front #(
  parameter int unsigned DEPTH = sha256_pkg::CmdDepth
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [31:0]       data_word,
  input  wire logic [2:0]        byte_count,
  input  wire logic              last_word,
  output logic                   cmd_valid,
  input  wire logic              cmd_take,
  output sha256_pkg::cmd_t       cmd
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  sha256_pkg::cmd_t queue [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0] level;
  sha256_pkg::cmd_t incoming;
  logic do_push;
  logic do_pop;

  always_comb begin
    incoming.word = data_word;
    if (last_word) begin
      incoming.kind = sha256_pkg::CMD_FINAL;
      incoming.count = (byte_count > 3'd4) ? 3'd4 : byte_count;
    end else begin
      incoming.kind = sha256_pkg::CMD_WORD;
      incoming.count = 3'd4;
    end
  end

  assign full = (level == (AW+1)'(DEPTH));
  assign cmd_valid = (level != '0);
  assign do_push = push && !full;
  assign do_pop = cmd_take && cmd_valid;
  assign cmd = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      queue[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      level <= level + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

  `SHA_ASSERT(a_level_bound, clk, rst, level <= (AW+1)'(DEPTH), "queue level overflow")
  `SHA_ASSERT(a_no_pop_empty, clk, rst, cmd_take |-> cmd_valid, "pop from empty queue")
  `SHA_ASSERT(a_level_step, clk, rst, (do_push && !do_pop) |=> level == $past(level) + 1'b1,
    "queue level did not advance")
endmodule
`default_nettype wire

/* design/sha256_core.sv */
// ----------------------------------------------------------------------------
// SHA-256 core
// Fills the block buffer, pads, runs 64 rounds per block and emits digests.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sha256_hash_engine_defines.svh"
module sha256_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              double_mode,
  input  wire logic              cmd_valid,
  output logic                   cmd_take,
  input  wire sha256_pkg::cmd_t  cmd,
  output logic                   res_valid,
  input  wire logic              res_take,
  output logic [63:0]            res_digest,
  output logic [1:0]             res_index,
  output sha256_pkg::status_t    status
);
  sha256_pkg::state_t state, state_next;

  logic [31:0] chain [8];
  logic [31:0] w [16];
  logic [31:0] v [8];
  logic [3:0]  fill;
  logic [60:0] msg_bytes;
  logic [5:0]  round;
  logic [63:0] bit_len;
  logic        second;
  logic        dbl;
  logic        pad_pending;
  logic        pad_word_due;
  logic [2:0]  load_idx;
  logic [1:0]  part;
  logic [31:0] final_word;
  logic [31:0] first_dig [8];

  // control decisions for a word written into the buffer
  logic        write_en;
  logic [31:0] write_word;
  logic        start_block;
  logic [31:0] wt;
  logic [31:0] w15, w2, s0, s1, t1, t2, sched;

  assign w15 = w[1];
  assign w2 = w[14];
  assign s0 = sha256_pkg::rotr(w15, 7) ^ sha256_pkg::rotr(w15, 18) ^ (w15 >> 3);
  assign s1 = sha256_pkg::rotr(w2, 17) ^ sha256_pkg::rotr(w2, 19) ^ (w2 >> 10);
  assign sched = w[0] + s0 + w[9] + s1;
  assign wt = w[0];
  assign t1 = v[7] + (sha256_pkg::rotr(v[4], 6) ^ sha256_pkg::rotr(v[4], 11)
            ^ sha256_pkg::rotr(v[4], 25)) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
            + sha256_pkg::round_k(round) + wt;
  assign t2 = (sha256_pkg::rotr(v[0], 2) ^ sha256_pkg::rotr(v[0], 13)
            ^ sha256_pkg::rotr(v[0], 22)) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));

  always_comb begin
    case (cmd.count)
      3'd1: final_word = {cmd.word[31:24], 24'h800000};
      3'd2: final_word = {cmd.word[31:16], 16'h8000};
      3'd3: final_word = {cmd.word[31:8], 8'h80};
      3'd0: final_word = sha256_pkg::PAD_WORD;
      default: final_word = cmd.word;
    endcase
  end

  always_comb begin
    state_next = state;
    cmd_take = 1'b0;
    write_en = 1'b0;
    write_word = '0;
    start_block = 1'b0;
    case (state)
      sha256_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          cmd_take = 1'b1;
          write_en = 1'b1;
          write_word = (cmd.kind == sha256_pkg::CMD_FINAL) ? final_word : cmd.word;
          if (fill == 4'd15) begin
            start_block = 1'b1;
            state_next = sha256_pkg::ST_ROUND;
          end else if (cmd.kind == sha256_pkg::CMD_FINAL) begin
            state_next = (cmd.count == 3'd4) ? sha256_pkg::ST_PAD_WORD
                                             : sha256_pkg::ST_PAD_FILL;
          end
        end
      end
      sha256_pkg::ST_PAD_WORD: begin
        write_en = 1'b1;
        write_word = sha256_pkg::PAD_WORD;
        if (fill == 4'd15) begin
          start_block = 1'b1;
          state_next = sha256_pkg::ST_ROUND;
        end else begin
          state_next = sha256_pkg::ST_PAD_FILL;
        end
      end
      sha256_pkg::ST_PAD_FILL: begin
        write_en = 1'b1;
        if (fill == sha256_pkg::LEN_SLOT && !pad_pending) begin
          write_word = bit_len[63:32];
        end else if (fill == 4'd15 && !pad_pending) begin
          write_word = bit_len[31:0];
        end else begin
          write_word = '0;
        end
        if (fill == 4'd15) begin
          start_block = 1'b1;
          state_next = sha256_pkg::ST_ROUND;
        end
      end
      sha256_pkg::ST_DBL_LOAD: begin
        write_en = 1'b1;
        write_word = first_dig[load_idx];
        if (load_idx == 3'd7) begin
          state_next = sha256_pkg::ST_PAD_WORD;
        end
      end
      sha256_pkg::ST_ROUND: begin
        if (round == 6'd63) begin
          state_next = sha256_pkg::ST_FOLD;
        end
      end
      sha256_pkg::ST_FOLD: begin
        if (pad_word_due) begin
          state_next = sha256_pkg::ST_PAD_WORD;
        end else if (pad_pending) begin
          state_next = sha256_pkg::ST_PAD_FILL;
        end else if (!second) begin
          state_next = sha256_pkg::ST_IDLE;
        end else if (dbl) begin
          state_next = sha256_pkg::ST_DBL_LOAD;
        end else begin
          state_next = sha256_pkg::ST_EMIT;
        end
      end
      sha256_pkg::ST_EMIT: begin
        if (res_take && part == 2'd3) begin
          state_next = sha256_pkg::ST_IDLE;
        end
      end
      default: state_next = sha256_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha256_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (write_en && state != sha256_pkg::ST_ROUND) begin
      w[fill] <= write_word;
    end else if (state == sha256_pkg::ST_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i+1];
      end
      w[15] <= sched;
    end
  end

  always_ff @(posedge clk) begin
    if (start_block) begin
      for (int i = 0; i < 8; i++) begin
        v[i] <= chain[i];
      end
    end else if (state == sha256_pkg::ST_ROUND) begin
      v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
      v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) begin
        chain[i] <= sha256_pkg::IV[255 - 32*i -: 32];
      end
      fill <= '0;
      msg_bytes <= '0;
      round <= '0;
      second <= 1'b0;
      dbl <= 1'b0;
      pad_pending <= 1'b0;
      pad_word_due <= 1'b0;
      load_idx <= '0;
      part <= '0;
      bit_len <= '0;
    end else begin
      if (write_en) begin
        fill <= fill + 4'd1;
      end
      if (state == sha256_pkg::ST_IDLE && cmd_valid) begin
        msg_bytes <= msg_bytes + 61'(cmd.count);
        if (cmd.kind == sha256_pkg::CMD_FINAL) begin
          bit_len <= {msg_bytes + 61'(cmd.count), 3'b000};
          second <= 1'b1;
          dbl <= double_mode;
          pad_pending <= (cmd.count != 3'd4) && (fill > 4'd13);
          pad_word_due <= (cmd.count == 3'd4) && (fill == 4'd15);
        end
      end
      if (state == sha256_pkg::ST_FOLD) begin
        pad_pending <= 1'b0;
      end
      if (state == sha256_pkg::ST_PAD_WORD) begin
        pad_word_due <= 1'b0;
        if (fill >= 4'd14) begin
          pad_pending <= 1'b1;
        end
      end
      if (state == sha256_pkg::ST_ROUND) begin
        round <= round + 6'd1;
      end
      if (state == sha256_pkg::ST_FOLD) begin
        for (int i = 0; i < 8; i++) begin
          chain[i] <= chain[i] + v[i];
        end
      end
      if (state == sha256_pkg::ST_FOLD && !pad_word_due && !pad_pending && second && dbl) begin
        dbl <= 1'b0;
        bit_len <= 64'd256;
        load_idx <= '0;
      end
      if (state == sha256_pkg::ST_DBL_LOAD) begin
        load_idx <= load_idx + 3'd1;
        if (load_idx == 3'd0) begin
          for (int i = 0; i < 8; i++) begin
            chain[i] <= sha256_pkg::IV[255 - 32*i -: 32];
          end
        end
      end
      if (state == sha256_pkg::ST_EMIT && res_take) begin
        part <= part + 2'd1;
        if (part == 2'd3) begin
          for (int i = 0; i < 8; i++) begin
            chain[i] <= sha256_pkg::IV[255 - 32*i -: 32];
          end
          fill <= '0;
          msg_bytes <= '0;
          second <= 1'b0;
        end
      end
    end
  end

  // Digest words for the double pass are staged before the chain is reset.
  always_ff @(posedge clk) begin
    if (state == sha256_pkg::ST_FOLD) begin
      for (int i = 0; i < 8; i++) begin
        first_dig[i] <= chain[i] + v[i];
      end
    end
  end

  assign res_valid = (state == sha256_pkg::ST_EMIT);
  assign res_index = part;
  assign res_digest = {chain[{part, 1'b0}], chain[{part, 1'b1}]};
  assign status.busy = (state != sha256_pkg::ST_IDLE);
  assign status.emitting = res_valid;

  `SHA_ASSERT(a_round_idle, clk, rst, (state != sha256_pkg::ST_ROUND) |-> round == 6'd0,
    "round counter active outside rounds")
  `SHA_ASSERT(a_emit_stable, clk, rst, (res_valid && !res_take) |=> $stable(part),
    "digest part moved without transfer")
  `SHA_ASSERT(a_take_idle, clk, rst, cmd_take |-> state == sha256_pkg::ST_IDLE,
    "command taken while busy")
endmodule
`default_nettype wire
